[rtl/tfdt_pkg.sv]
// ---------------------------------------------------------------------------
// tfdt_pkg: shared definitions for the fragment depth test core
// Constants, request codes and the control bundles passed between the
// sequencer and the shared arithmetic units.
// ---------------------------------------------------------------------------
package tfdt_pkg;

  // Depth store geometry (the store is addressed row by row)
  localparam int MAX_WIDTH     = 64;
  localparam int MAX_HEIGHT    = 64;
  localparam int X_W           = $clog2(MAX_WIDTH);
  localparam int Y_W           = $clog2(MAX_HEIGHT);
  localparam int ADDR_W        = X_W + Y_W;
  localparam int DEPTH_ENTRIES = MAX_WIDTH * MAX_HEIGHT;

  localparam logic [23:0] FAR_DEPTH = 24'hFFFFFF;

  // Screen coordinates are signed Q.8 pixels saturated to 22 bits
  localparam int SCR_W   = 22;
  localparam int SCR_LIM = 2 ** (SCR_W - 1);

  // Request codes
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_TEST  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // Face culling modes
  localparam logic [1:0] CULL_FRONT = 2'd1;
  localparam logic [1:0] CULL_BACK  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_CULL   = 2'd2;

  // Shared multiplier and accumulator
  localparam int MUL_W = 33;
  localparam int ACC_W = 52;

  // Shared serial divider
  localparam int DIV_W  = 48;
  localparam int QUO_W  = 47;
  localparam int STEP_W = 6;

  typedef struct packed {
    logic valid;
    logic clr;
    logic sub;
  } mac_ctl_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  rem_init;
    logic [DIV_W-1:0]  shin;
    logic [DIV_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage

[rtl/triangle_fragment_depth_test_core.sv]
// ---------------------------------------------------------------------------
// triangle_fragment_depth_test_core: triangle coverage and depth test
// Stores one triangle, tests pixels against it and keeps a depth store.
// ---------------------------------------------------------------------------
// Usage. Requests arrive on the in_valid / in_ready channel. A load request
// maps one clip-space vertex to screen space; loading slot 2 also decides
// face culling. A test request checks one pixel for coverage, interpolates
// its depth and updates the depth store when the fragment is nearer. A clear
// request sets one depth entry back to far. Every request produces exactly
// one result on the out_valid / out_ready channel.
// Timing. One request is in work at a time and in_ready is low meanwhile.
// The cost is set by the single serial divider (one quotient bit per cycle)
// and the shared multiplier: a vertex load runs two 47-step divisions, a
// covered test two 17-step weight divisions, one 25-step depth division
// and twelve products, while a clear or a test that is culled or off the
// viewport uses neither unit.
// Reset. After reset the core sweeps the 4096-entry depth store to far, one
// entry per cycle; in_ready stays low until the sweep ends. Configuration
// writes are taken at any time, including during the sweep.
// Stalls. A result waits in the output register while out_ready is low; the
// next request may be accepted meanwhile, and its result waits in turn.
// ---------------------------------------------------------------------------
module triangle_fragment_depth_test_core import tfdt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic [1:0]         vertex_slot,
  input  logic signed [31:0] clip_x,
  input  logic signed [31:0] clip_y,
  input  logic signed [31:0] clip_z,
  input  logic signed [31:0] clip_w,
  input  logic signed [11:0] pixel_x,
  input  logic signed [11:0] pixel_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               covered,
  output logic               depth_passed,
  output logic [23:0]        frag_depth,
  output logic [16:0]        weight_one,
  output logic [16:0]        weight_two,
  output logic               triangle_culled
);

  // Sequencer states
  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_DECODE = 4'd2;
  localparam logic [3:0] ST_MAC    = 4'd3;
  localparam logic [3:0] ST_MWAIT  = 4'd4;
  localparam logic [3:0] ST_MRES   = 4'd5;
  localparam logic [3:0] ST_LDIV   = 4'd6;
  localparam logic [3:0] ST_LDWAIT = 4'd7;
  localparam logic [3:0] ST_TCHK   = 4'd8;
  localparam logic [3:0] ST_WDIV   = 4'd9;
  localparam logic [3:0] ST_WWAIT  = 4'd10;
  localparam logic [3:0] ST_ZCHK   = 4'd11;
  localparam logic [3:0] ST_DDIV   = 4'd12;
  localparam logic [3:0] ST_DWAIT  = 4'd13;
  localparam logic [3:0] ST_DONE   = 4'd14;

  // Product programs run on the shared multiplier
  localparam logic [2:0] PROG_SCREEN = 3'd0;  // base * viewport size
  localparam logic [2:0] PROG_D      = 3'd1;  // determinant / facing cross product
  localparam logic [2:0] PROG_P      = 3'd2;
  localparam logic [2:0] PROG_Q      = 3'd3;
  localparam logic [2:0] PROG_Z      = 3'd4;
  localparam logic [2:0] PROG_W      = 3'd5;

  logic [3:0]  state;
  logic [2:0]  prog;
  logic [1:0]  mcnt;
  logic [1:0]  mlast;
  logic        lax;
  logic        wsel;
  logic        lneg;

  // Configuration
  logic [6:0]  screen_width;
  logic [6:0]  screen_height;
  logic [1:0]  cull_sel;

  // Request held for the duration of its work
  logic [1:0]         req_func;
  logic [1:0]         req_slot;
  logic signed [31:0] req_cx;
  logic signed [31:0] req_cy;
  logic signed [31:0] req_cz;
  logic signed [31:0] req_cw;
  logic signed [11:0] req_px;
  logic signed [11:0] req_py;

  // Triangle state
  logic signed [SCR_W-1:0] vx [3];
  logic signed [SCR_W-1:0] vy [3];
  logic signed [31:0]      vz [3];
  logic signed [31:0]      vw [3];
  logic                    culled;

  // Working values of a test
  logic signed [47:0] d_r;
  logic signed [47:0] p_r;
  logic signed [47:0] q_r;
  logic signed [48:0] zn_r;
  logic signed [48:0] wn_r;
  logic [16:0]        a16;
  logic [16:0]        b16;

  // Result being built
  logic        res_cov;
  logic        res_pass;
  logic [23:0] res_depth;
  logic [16:0] res_w1;
  logic [16:0] res_w2;

  // Depth store
  logic [23:0]       mem [DEPTH_ENTRIES];
  logic [23:0]       mem_q;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_waddr;
  logic [23:0]       mem_wdata;
  logic [ADDR_W-1:0] clr_idx;
  logic [ADDR_W-1:0] pix_addr;

  // Shared units
  mac_ctl_t                mac_ctl;
  logic signed [MUL_W-1:0] op_a;
  logic signed [MUL_W-1:0] op_b;
  logic signed [ACC_W-1:0] acc;
  div_req_t                div_req;
  logic                    div_busy;
  logic [QUO_W-1:0]        div_quot;
  logic                    div_rem_nz;

  // Combinational helpers
  logic signed [23:0] ax, ay, bx, by, qx, qy;
  logic signed [19:0] samp_x, samp_y;
  logic signed [17:0] c16;
  logic signed [MUL_W-1:0] base_x, base_y;
  logic [12:0] wl, hl;
  logic        test_in, clear_in;
  logic signed [ACC_W-1:0] acc_mag;
  logic [32:0] cw_mag;
  logic [QUO_W:0] lval, lval_neg;
  logic signed [SCR_W-1:0] coord;
  logic signed [47:0] dn, pn, qn;
  logic signed [48:0] pq_sum;
  logic        tri_ok;
  logic signed [48:0] znn, wnn;
  logic        depth_ok;
  logic [23:0] dq;

  tfdt_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  tfdt_div u_div (
    .clk    (clk),
    .rst    (rst),
    .req    (div_req),
    .busy   (div_busy),
    .quot   (div_quot),
    .rem_nz (div_rem_nz)
  );

  assign in_ready = (state == ST_IDLE);

  // Edge vectors relative to vertex 0 and the pixel centre
  assign samp_x = $signed({req_px, 8'h80});
  assign samp_y = $signed({req_py, 8'h80});
  assign ax = 24'(vx[1]) - 24'(vx[0]);
  assign ay = 24'(vy[1]) - 24'(vy[0]);
  assign bx = 24'(vx[2]) - 24'(vx[0]);
  assign by = 24'(vy[2]) - 24'(vy[0]);
  assign qx = 24'(samp_x) - 24'(vx[0]);
  assign qy = 24'(samp_y) - 24'(vy[0]);
  assign c16 = $signed(18'h10000 - {1'b0, a16} - {1'b0, b16});
  assign base_x = MUL_W'(req_cx) + MUL_W'(req_cw);
  assign base_y = MUL_W'(req_cw) - MUL_W'(req_cy);

  // Bounds: the viewport is limited to the size of the depth store
  assign wl = (13'(screen_width) < 13'(MAX_WIDTH)) ? 13'(screen_width) : 13'(MAX_WIDTH);
  assign hl = (13'(screen_height) < 13'(MAX_HEIGHT)) ? 13'(screen_height) : 13'(MAX_HEIGHT);
  assign test_in = !req_px[11] && !req_py[11] && (13'(req_px[10:0]) < wl)
                   && (13'(req_py[10:0]) < hl);
  assign clear_in = !req_px[11] && !req_py[11] && (13'(req_px[10:0]) < 13'(MAX_WIDTH))
                    && (13'(req_py[10:0]) < 13'(MAX_HEIGHT));
  assign pix_addr = {req_py[Y_W-1:0], req_px[X_W-1:0]};

  // Screen mapping: magnitude of the scaled numerator and of w
  assign acc_mag = acc[ACC_W-1] ? -acc : acc;
  assign cw_mag  = req_cw[31] ? 33'd0 - 33'(req_cw) : 33'(req_cw);

  // Floor division of a negative numerator rounds away from zero, then the
  // coordinate saturates to the 22-bit screen range. A zero w maps to zero.
  assign lval     = {1'b0, div_quot} + (QUO_W+1)'(div_rem_nz);
  assign lval_neg = ~lval + 1'b1;
  always_comb begin
    if (req_cw == '0) begin
      coord = '0;
    end else if (lneg) begin
      coord = (lval > (QUO_W+1)'(SCR_LIM)) ? SCR_W'(SCR_LIM) : lval_neg[SCR_W-1:0];
    end else begin
      coord = (div_quot >= QUO_W'(SCR_LIM)) ? SCR_W'(SCR_LIM - 1) : div_quot[SCR_W-1:0];
    end
  end

  // Sign normalisation so that the determinant is positive
  assign dn = d_r[47] ? -d_r : d_r;
  assign pn = d_r[47] ? -p_r : p_r;
  assign qn = d_r[47] ? -q_r : q_r;
  assign pq_sum = 49'(pn) + 49'(qn);
  assign tri_ok = (dn != '0) && !pn[47] && !qn[47] && (pq_sum <= 49'(dn));

  // Interpolated w made positive; depth must lie in (0,1]
  assign wnn = wn_r[48] ? -wn_r : wn_r;
  assign znn = wn_r[48] ? -zn_r : zn_r;
  assign depth_ok = (wnn != '0) && (znn > 0) && (znn <= wnn);

  // A quotient of exactly one saturates to the far value
  assign dq = (div_quot[QUO_W-1:24] != '0) ? FAR_DEPTH : div_quot[23:0];

  // Operand selection for the shared multiplier
  always_comb begin
    op_a    = '0;
    op_b    = '0;
    mac_ctl = '0;
    if (state == ST_MAC) begin
      mac_ctl.valid = 1'b1;
      mac_ctl.clr   = (mcnt == 2'd0);
      case (prog)
        PROG_SCREEN: begin
          op_a = lax ? base_y : base_x;
          op_b = lax ? MUL_W'(screen_height) : MUL_W'(screen_width);
        end
        PROG_D: begin
          op_a        = (mcnt == 2'd0) ? MUL_W'(ax) : MUL_W'(ay);
          op_b        = (mcnt == 2'd0) ? MUL_W'(by) : MUL_W'(bx);
          mac_ctl.sub = (mcnt != 2'd0);
        end
        PROG_P: begin
          op_a        = (mcnt == 2'd0) ? MUL_W'(qx) : MUL_W'(qy);
          op_b        = (mcnt == 2'd0) ? MUL_W'(by) : MUL_W'(bx);
          mac_ctl.sub = (mcnt != 2'd0);
        end
        PROG_Q: begin
          op_a        = (mcnt == 2'd0) ? MUL_W'(ax) : MUL_W'(ay);
          op_b        = (mcnt == 2'd0) ? MUL_W'(qy) : MUL_W'(qx);
          mac_ctl.sub = (mcnt != 2'd0);
        end
        PROG_Z, PROG_W: begin
          case (mcnt)
            2'd0:    op_a = MUL_W'(c16);
            2'd1:    op_a = MUL_W'($signed({1'b0, a16}));
            default: op_a = MUL_W'($signed({1'b0, b16}));
          endcase
          case (mcnt)
            2'd0:    op_b = (prog == PROG_Z) ? MUL_W'(vz[0]) : MUL_W'(vw[0]);
            2'd1:    op_b = (prog == PROG_Z) ? MUL_W'(vz[1]) : MUL_W'(vw[1]);
            default: op_b = (prog == PROG_Z) ? MUL_W'(vz[2]) : MUL_W'(vw[2]);
          endcase
        end
        default: begin
          mac_ctl = '0;
        end
      endcase
    end
  end

  always_comb begin
    case (prog)
      PROG_SCREEN:    mlast = 2'd0;
      PROG_Z, PROG_W: mlast = 2'd2;
      default:        mlast = 2'd1;
    endcase
  end

  // Divider requests
  always_comb begin
    div_req = '0;
    case (state)
      ST_LDIV: begin
        div_req.start    = 1'b1;
        div_req.rem_init = '0;
        div_req.shin     = {acc_mag[38:0], 9'd0};
        div_req.divisor  = DIV_W'(cw_mag);
        div_req.steps    = STEP_W'(46);
      end
      ST_WDIV: begin
        div_req.start    = 1'b1;
        div_req.rem_init = wsel ? q_r : p_r;
        div_req.divisor  = d_r;
        div_req.steps    = STEP_W'(16);
      end
      ST_DDIV: begin
        div_req.start    = 1'b1;
        div_req.rem_init = zn_r[DIV_W-1:0];
        div_req.divisor  = wn_r[DIV_W-1:0];
        div_req.steps    = STEP_W'(24);
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  // Depth store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pix_addr;
    mem_wdata = FAR_DEPTH;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
      end
      ST_DECODE: begin
        mem_we = (req_func == FUNC_CLEAR) && clear_in;
      end
      ST_DWAIT: begin
        mem_we    = !div_busy && (dq < mem_q);
        mem_wdata = dq;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign mem_re = (state == ST_DECODE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[pix_addr];
    end
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      clr_idx         <= '0;
      screen_width    <= 7'd64;
      screen_height   <= 7'd64;
      cull_sel        <= '0;
      culled          <= 1'b0;
      prog            <= PROG_SCREEN;
      mcnt            <= '0;
      lax             <= 1'b0;
      wsel            <= 1'b0;
      lneg            <= 1'b0;
      out_valid       <= 1'b0;
      covered         <= 1'b0;
      depth_passed    <= 1'b0;
      frag_depth      <= '0;
      weight_one      <= '0;
      weight_two      <= '0;
      triangle_culled <= 1'b0;
      res_cov         <= 1'b0;
      res_pass        <= 1'b0;
      res_depth       <= '0;
      res_w1          <= '0;
      res_w2          <= '0;
      for (int i = 0; i < 3; i++) begin
        vx[i] <= '0;
        vy[i] <= '0;
        vz[i] <= '0;
        vw[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_WIDTH:  screen_width  <= cfg_data;
          CFG_HEIGHT: screen_height <= cfg_data;
          CFG_CULL:   cull_sel      <= cfg_data[1:0];
          default:    ;
        endcase
      end

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == ADDR_W'(DEPTH_ENTRIES - 1)) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (in_valid) begin
            req_func <= func;
            req_slot <= vertex_slot;
            req_cx   <= clip_x;
            req_cy   <= clip_y;
            req_cz   <= clip_z;
            req_cw   <= clip_w;
            req_px   <= pixel_x;
            req_py   <= pixel_y;
            state    <= ST_DECODE;
          end
        end

        ST_DECODE: begin
          res_cov   <= 1'b0;
          res_pass  <= 1'b0;
          res_depth <= '0;
          res_w1    <= '0;
          res_w2    <= '0;
          mcnt      <= '0;
          lax       <= 1'b0;
          wsel      <= 1'b0;
          state     <= ST_DONE;
          case (req_func)
            FUNC_LOAD: begin
              if (req_slot != 2'd3) begin
                prog  <= PROG_SCREEN;
                state <= ST_MAC;
              end
            end
            FUNC_TEST: begin
              if (!culled && test_in) begin
                prog  <= PROG_D;
                state <= ST_MAC;
              end
            end
            default: ;
          endcase
        end

        ST_MAC: begin
          mcnt <= mcnt + 1'b1;
          if (mcnt == mlast) begin
            state <= ST_MWAIT;
          end
        end

        ST_MWAIT: begin
          mcnt  <= '0;
          state <= ST_MRES;
        end

        ST_MRES: begin
          case (prog)
            PROG_SCREEN: begin
              lneg  <= acc[ACC_W-1] ^ req_cw[31];
              state <= ST_LDIV;
            end
            PROG_D: begin
              if (req_func == FUNC_LOAD) begin
                // Negative screen cross product means a front face
                culled <= ((cull_sel == CULL_FRONT) && acc[ACC_W-1])
                          || ((cull_sel == CULL_BACK) && !acc[ACC_W-1]);
                state  <= ST_DONE;
              end else begin
                d_r   <= acc[47:0];
                prog  <= PROG_P;
                state <= ST_MAC;
              end
            end
            PROG_P: begin
              p_r   <= acc[47:0];
              prog  <= PROG_Q;
              state <= ST_MAC;
            end
            PROG_Q: begin
              q_r   <= acc[47:0];
              state <= ST_TCHK;
            end
            PROG_Z: begin
              zn_r  <= acc[48:0];
              prog  <= PROG_W;
              state <= ST_MAC;
            end
            default: begin
              wn_r  <= acc[48:0];
              state <= ST_ZCHK;
            end
          endcase
        end

        ST_LDIV: begin
          state <= ST_LDWAIT;
        end

        ST_LDWAIT: begin
          if (!div_busy) begin
            if (!lax) begin
              vx[req_slot] <= coord;
              lax          <= 1'b1;
              prog         <= PROG_SCREEN;
              state        <= ST_MAC;
            end else begin
              vy[req_slot] <= coord;
              vz[req_slot] <= req_cz;
              vw[req_slot] <= req_cw;
              if (req_slot == 2'd2) begin
                prog  <= PROG_D;
                state <= ST_MAC;
              end else begin
                state <= ST_DONE;
              end
            end
          end
        end

        ST_TCHK: begin
          d_r   <= dn;
          p_r   <= pn;
          q_r   <= qn;
          state <= tri_ok ? ST_WDIV : ST_DONE;
        end

        ST_WDIV: begin
          state <= ST_WWAIT;
        end

        ST_WWAIT: begin
          if (!div_busy) begin
            if (!wsel) begin
              a16   <= div_quot[16:0];
              wsel  <= 1'b1;
              state <= ST_WDIV;
            end else begin
              b16   <= div_quot[16:0];
              prog  <= PROG_Z;
              state <= ST_MAC;
            end
          end
        end

        ST_ZCHK: begin
          res_cov <= 1'b1;
          res_w1  <= a16;
          res_w2  <= b16;
          zn_r    <= znn;
          wn_r    <= wnn;
          state   <= depth_ok ? ST_DDIV : ST_DONE;
        end

        ST_DDIV: begin
          state <= ST_DWAIT;
        end

        ST_DWAIT: begin
          if (!div_busy) begin
            res_depth <= dq;
            res_pass  <= (dq < mem_q);
            state     <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            covered         <= res_cov;
            depth_passed    <= res_pass;
            frag_depth      <= res_depth;
            weight_one      <= res_w1;
            weight_two      <= res_w2;
            triangle_culled <= culled;
            state           <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/tfdt_mac.sv]
// ---------------------------------------------------------------------------
// tfdt_mac: shared multiply-accumulate unit
// Registered signed product followed by an accumulator that clears, adds or
// subtracts one product per cycle.
// ---------------------------------------------------------------------------
module tfdt_mac import tfdt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_ctl_t                ctl,
  input  logic signed [MUL_W-1:0] op_a,
  input  logic signed [MUL_W-1:0] op_b,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [2*MUL_W-1:0] full;
  logic signed [ACC_W-1:0]   prod;
  logic signed [ACC_W-1:0]   base;
  mac_ctl_t                  ctl_q;

  assign full = op_a * op_b;
  assign base = ctl_q.clr ? '0 : acc;

  always_ff @(posedge clk) begin
    prod <= full[ACC_W-1:0];
    if (rst) begin
      ctl_q <= '0;
      acc   <= '0;
    end else begin
      ctl_q <= ctl;
      if (ctl_q.valid) begin
        acc <= ctl_q.sub ? base - prod : base + prod;
      end
    end
  end

endmodule

[rtl/tfdt_div.sv]
// ---------------------------------------------------------------------------
// tfdt_div: shared restoring divider
// One quotient bit per cycle. The first step compares the preloaded
// remainder unshifted; each later step shifts in one dividend bit.
// ---------------------------------------------------------------------------
module tfdt_div import tfdt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             busy,
  output logic [QUO_W-1:0] quot,
  output logic             rem_nz
);

  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  shin;
  logic [DIV_W-1:0]  dvs;
  logic [STEP_W-1:0] cnt;
  logic              first;
  logic [DIV_W:0]    r2;
  logic [DIV_W:0]    diff;
  logic              ge;

  assign r2     = first ? {1'b0, rem} : {rem, shin[DIV_W-1]};
  assign diff   = r2 - {1'b0, dvs};
  assign ge     = (r2 >= {1'b0, dvs});
  assign rem_nz = |rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      first <= 1'b0;
      cnt   <= '0;
      rem   <= '0;
      shin  <= '0;
      dvs   <= '0;
      quot  <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      first <= 1'b1;
      cnt   <= req.steps;
      rem   <= req.rem_init;
      shin  <= req.shin;
      dvs   <= req.divisor;
      quot  <= '0;
    end else if (busy) begin
      rem   <= ge ? diff[DIV_W-1:0] : r2[DIV_W-1:0];
      quot  <= {quot[QUO_W-2:0], ge};
      first <= 1'b0;
      if (!first) begin
        shin <= {shin[DIV_W-2:0], 1'b0};
        cnt  <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for triangle_fragment_depth_test_core
// Drives vertex loads, pixel tests and depth clears through the request
// channel under several viewport and culling settings, predicts every
// result with a behavioural copy of the core and compares field by field.
// ---------------------------------------------------------------------------
module tb;
  import tfdt_pkg::*;

  localparam int          CLK_HALF    = 10;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          RAND_ITEMS  = 850;
  localparam int          PHASES      = 10;
  localparam logic [1:0]  FUNC_SPARE  = 2'd3;  // undefined request code
  localparam logic [1:0]  SLOT_SPARE  = 2'd3;  // slot that loads nothing
  localparam logic [1:0]  CULL_NONE   = 2'd0;
  localparam logic [1:0]  CULL_SPARE  = 2'd3;  // behaves as no culling
  localparam logic [31:0] ONE_Q16     = 32'h0001_0000;

  typedef struct packed {
    logic [1:0]         func;
    logic [1:0]         slot;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic signed [31:0] cw;
    logic signed [11:0] px;
    logic signed [11:0] py;
  } frag_req_t;

  typedef struct packed {
    logic        cov;
    logic        pass;
    logic [23:0] depth;
    logic [16:0] w1;
    logic [16:0] w2;
    logic        culled;
  } frag_res_t;

  typedef struct packed {
    logic      fixed;
    frag_res_t res;
  } res_tag_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [6:0]         cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  frag_req_t          drv = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               covered, depth_passed, triangle_culled;
  logic [23:0]        frag_depth;
  logic [16:0]        weight_one, weight_two;

  always #CLK_HALF clk = ~clk;

  triangle_fragment_depth_test_core u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(drv.func), .vertex_slot(drv.slot),
    .clip_x(drv.cx), .clip_y(drv.cy), .clip_z(drv.cz), .clip_w(drv.cw),
    .pixel_x(drv.px), .pixel_y(drv.py),
    .out_valid(out_valid), .out_ready(out_ready),
    .covered(covered), .depth_passed(depth_passed), .frag_depth(frag_depth),
    .weight_one(weight_one), .weight_two(weight_two),
    .triangle_culled(triangle_culled)
  );

  // -------------------------------------------------------------------------
  // Shadow of the core: configuration, the stored triangle and depth store.
  // -------------------------------------------------------------------------
  logic [6:0]  sh_width, sh_height;
  logic [1:0]  sh_cull;
  longint      scr_x [3], scr_y [3], vert_z [3], vert_w [3];
  logic        sh_culled;
  logic [23:0] zbuf [DEPTH_ENTRIES];

  // Stats for the closing summary
  int n_tests, n_covered, n_passed, n_culled_tri, n_results;

  // Clip to screen in Q.8 pixels: floor(base*size*128/w), saturated.
  function automatic longint clip_to_screen(longint base, longint w, longint size);
    longint num, q;
    num = base * size * 128;
    if (w == 0) return 0;
    if (w < 0) begin
      num = -num;
      w   = -w;
    end
    q = num / w;
    if (num % w != 0 && num < 0) q = q - 1;
    if (q > SCR_LIM - 1) q = SCR_LIM - 1;
    if (q < -SCR_LIM) q = -SCR_LIM;
    return q;
  endfunction

  // Works out the result of one request and updates the shadow state.
  function automatic frag_res_t depth_test_predict(frag_req_t r);
    frag_res_t                res;
    longint                   sx, sy, e1x, e1y, e2x, e2y, px, py, wl, hl;
    logic signed [127:0]      d, p, q, a16, b16, c16, zn, wn, quo;
    logic                     front;
    int                       idx;
    res = '0;
    px  = r.px;
    py  = r.py;
    if (r.func == FUNC_LOAD) begin
      if (r.slot != SLOT_SPARE) begin
        sx = clip_to_screen(longint'(r.cx) + longint'(r.cw), r.cw, sh_width);
        sy = clip_to_screen(longint'(r.cw) - longint'(r.cy), r.cw, sh_height);
        scr_x[r.slot]  = sx;
        scr_y[r.slot]  = sy;
        vert_z[r.slot] = r.cz;
        vert_w[r.slot] = r.cw;
        if (r.slot == 2'd2) begin
          e1x   = scr_x[1] - scr_x[0];
          e1y   = scr_y[1] - scr_y[0];
          e2x   = sx - scr_x[0];
          e2y   = sy - scr_y[0];
          front = (e1x * e2y - e2x * e1y) < 0;
          sh_culled = (sh_cull == CULL_FRONT && front) || (sh_cull == CULL_BACK && !front);
          if (sh_culled) n_culled_tri++;
        end
      end
    end else if (r.func == FUNC_CLEAR) begin
      if (px >= 0 && px < MAX_WIDTH && py >= 0 && py < MAX_HEIGHT)
        zbuf[py * MAX_WIDTH + px] = FAR_DEPTH;
    end else if (r.func == FUNC_TEST) begin
      n_tests++;
      wl = (sh_width < MAX_WIDTH) ? sh_width : MAX_WIDTH;
      hl = (sh_height < MAX_HEIGHT) ? sh_height : MAX_HEIGHT;
      if (!sh_culled && px >= 0 && px < wl && py >= 0 && py < hl) begin
        e1x = scr_x[1] - scr_x[0];
        e1y = scr_y[1] - scr_y[0];
        e2x = scr_x[2] - scr_x[0];
        e2y = scr_y[2] - scr_y[0];
        sx  = px * 256 + 128 - scr_x[0];
        sy  = py * 256 + 128 - scr_y[0];
        d = 128'(e1x) * e2y - 128'(e1y) * e2x;
        p = 128'(sx) * e2y - 128'(sy) * e2x;
        q = 128'(e1x) * sy - 128'(e1y) * sx;
        if (d < 0) begin
          d = -d;
          p = -p;
          q = -q;
        end
        if (d != 0 && p >= 0 && q >= 0 && p + q <= d) begin
          a16 = (p * 65536) / d;
          b16 = (q * 65536) / d;
          c16 = 65536 - a16 - b16;
          zn  = c16 * vert_z[0] + a16 * vert_z[1] + b16 * vert_z[2];
          wn  = c16 * vert_w[0] + a16 * vert_w[1] + b16 * vert_w[2];
          res.cov = 1'b1;
          res.w1  = a16[16:0];
          res.w2  = b16[16:0];
          n_covered++;
          if (wn < 0) begin
            wn = -wn;
            zn = -zn;
          end
          if (wn != 0 && zn > 0 && zn <= wn) begin
            quo = (zn <<< 24) / wn;
            if (quo > FAR_DEPTH) quo = FAR_DEPTH;
            res.depth = quo[23:0];
            idx = py * MAX_WIDTH + px;
            if (res.depth < zbuf[idx]) begin
              zbuf[idx] = res.depth;
              res.pass  = 1'b1;
              n_passed++;
            end
          end
        end
      end
    end
    res.culled = sh_culled;
    return res;
  endfunction

  // -------------------------------------------------------------------------
  // Monitor: accepted requests are predicted, accepted results are checked
  // against the oldest outstanding expectation.
  // -------------------------------------------------------------------------
  frag_res_t   pending_results [$];
  res_tag_t    typed_results [$];
  int unsigned req_count = 0;
  int          n_errors = 0;
  int          n_cycles = 0;

  task automatic report_mismatch(string what, frag_res_t e, frag_res_t a);
    n_errors++;
    if (n_errors <= 10)
      $display("tb: %s: expected cov=%0d pass=%0d depth=%06h w1=%05h w2=%05h cull=%0d, got cov=%0d pass=%0d depth=%06h w1=%05h w2=%05h cull=%0d",
               what, e.cov, e.pass, e.depth, e.w1, e.w2, e.culled,
               a.cov, a.pass, a.depth, a.w1, a.w2, a.culled);
  endtask

  always @(posedge clk) begin
    frag_res_t got, want;
    res_tag_t  tag;
    n_cycles <= n_cycles + 1;
    if (!rst) begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_WIDTH:  sh_width  = cfg_data;
          CFG_HEIGHT: sh_height = cfg_data;
          CFG_CULL:   sh_cull   = cfg_data[1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{covered, depth_passed, frag_depth, weight_one, weight_two, triangle_culled};
        n_results++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing outstanding", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) report_mismatch("result mismatch", want, got);
        end
      end
      if (in_valid && in_ready) begin
        want = depth_test_predict(drv);
        tag  = typed_results.pop_front();
        // Rows with a hand-written answer are checked against that answer.
        if (tag.fixed) want = tag.res;
        pending_results.push_back(want);
        req_count <= req_count + 1;
      end
    end
  end

  always @(posedge clk) begin
    if (n_cycles > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", n_cycles);
      $display("tb: done, errors");
      $finish;
    end
  end

  // Receiver: stalls about ten percent of the time, except during the calm phase.
  logic calm = 1'b0;
  always @(negedge clk) out_ready <= calm || ($urandom_range(0, 99) >= 10);

  // -------------------------------------------------------------------------
  // Sender
  // -------------------------------------------------------------------------
  task automatic send_request(frag_req_t r, logic fixed = 1'b0, frag_res_t res = '0);
    int unsigned target;
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    typed_results.push_back('{fixed, res});
    target   = req_count + 1;
    drv      = r;
    in_valid = 1'b1;
    do @(negedge clk); while (req_count != target);
  endtask

  // Holds back until every outstanding result has come and the core is idle.
  task automatic drain;
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [6:0] value);
    cfg_write = 1'b1;
    cfg_index = index;
    cfg_data  = value;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  function automatic frag_req_t make_req(logic [1:0] f, logic [1:0] s, logic [31:0] x,
                                         logic [31:0] y, logic [31:0] z, logic [31:0] w,
                                         logic [11:0] px, logic [11:0] py);
    return '{f, s, x, y, z, w, px, py};
  endfunction

  // Random clip-space vertex: mostly a sensible w with x, y in about
  // [-1.5w, 1.5w] and z in about [-0.2w, 1.2w]; sometimes raw noise.
  function automatic frag_req_t rand_vertex(logic [1:0] s);
    frag_req_t r;
    longint    w, kx, ky, kz;
    int        pick;
    pick = $urandom_range(0, 99);
    w  = $urandom_range(32768, 262144);
    if (pick < 4) w = -w;
    kx = longint'($urandom_range(0, 196608)) - 98304;
    ky = longint'($urandom_range(0, 196608)) - 98304;
    kz = longint'($urandom_range(0, 91750)) - 13107;
    r = make_req(FUNC_LOAD, s, (w * kx) >>> 16, (w * ky) >>> 16, (w * kz) >>> 16, w,
                 $urandom, $urandom);
    if (pick >= 4 && pick < 7) r.cw = '0;
    if (pick >= 7 && pick < 12) begin
      r.cx = $urandom;
      r.cy = $urandom;
      r.cz = $urandom;
      r.cw = $urandom;
    end
    return r;
  endfunction

  function automatic frag_req_t rand_pixel(logic [1:0] f);
    frag_req_t r;
    r      = '0;
    r.func = f;
    r.slot = $urandom;
    r.cx   = $urandom;
    r.cy   = $urandom;
    r.cz   = $urandom;
    r.cw   = $urandom;
    if ($urandom_range(0, 99) < 8) begin
      r.px = $urandom;
      r.py = $urandom;
    end else begin
      r.px = $urandom_range(0, MAX_WIDTH);
      r.py = $urandom_range(0, MAX_HEIGHT);
    end
    return r;
  endfunction

  // Directed rows. The answer is written in where it is obvious; a zero
  // result (not culled) stands for loads, clears and rejected tests.
  typedef struct packed {
    frag_req_t req;
    logic      fixed;
    frag_res_t res;
  } stim_row_t;

  stim_row_t directed [$];

  initial begin
    frag_req_t   r;
    logic [6:0]  pw, ph;
    logic [1:0]  pc;
    int          sent, per_phase, n_tris, k;
    int unsigned slots [3];

    sh_width  = 7'd64;
    sh_height = 7'd64;
    sh_cull   = CULL_NONE;
    sh_culled = 1'b0;
    foreach (scr_x[i]) begin
      scr_x[i]  = 0;
      scr_y[i]  = 0;
      vert_z[i] = 0;
      vert_w[i] = 0;
    end
    foreach (zbuf[i]) zbuf[i] = FAR_DEPTH;

    // Test before any triangle: all vertices sit at the origin, so the
    // triangle is degenerate and nothing is covered.
    directed.push_back('{make_req(FUNC_TEST, 2'd0, 0, 0, 0, 0, 12'd0, 12'd0), 1'b1, '0});
    directed.push_back('{make_req(FUNC_CLEAR, 2'd0, 0, 0, 0, 0, 12'd0, 12'd0), 1'b1, '0});
    directed.push_back('{make_req(FUNC_CLEAR, 2'd0, 0, 0, 0, 0, 12'hFFF, 12'h800), 1'b1, '0});
    directed.push_back('{make_req(FUNC_SPARE, 2'd0, '1, '1, '1, '1, 12'd5, 12'd5), 1'b1, '0});
    directed.push_back('{make_req(FUNC_LOAD, SLOT_SPARE, ONE_Q16, ONE_Q16, 0, ONE_Q16,
                                  12'd0, 12'd0), 1'b1, '0});
    // A triangle over the lower-left half of the viewport, depth one half.
    directed.push_back('{make_req(FUNC_LOAD, 2'd0, -ONE_Q16, -ONE_Q16, 32'h8000, ONE_Q16,
                                  12'd0, 12'd0), 1'b1, '0});
    directed.push_back('{make_req(FUNC_LOAD, 2'd1, ONE_Q16, -ONE_Q16, 32'h8000, ONE_Q16,
                                  12'd0, 12'd0), 1'b1, '0});
    directed.push_back('{make_req(FUNC_LOAD, 2'd2, -ONE_Q16, ONE_Q16, 32'h8000, ONE_Q16,
                                  12'd0, 12'd0), 1'b1, '0});
    directed.push_back('{make_req(FUNC_TEST, 2'd0, 0, 0, 0, 0, 12'd10, 12'd50), 1'b0, '0});
    directed.push_back('{make_req(FUNC_TEST, 2'd0, 0, 0, 0, 0, 12'd10, 12'd50), 1'b0, '0});
    directed.push_back('{make_req(FUNC_CLEAR, 2'd0, 0, 0, 0, 0, 12'd10, 12'd50), 1'b1, '0});
    directed.push_back('{make_req(FUNC_TEST, 2'd0, 0, 0, 0, 0, 12'd10, 12'd50), 1'b0, '0});
    directed.push_back('{make_req(FUNC_TEST, 2'd0, 0, 0, 0, 0, 12'd0, 12'd63), 1'b0, '0});
    directed.push_back('{make_req(FUNC_TEST, 2'd0, 0, 0, 0, 0, 12'd63, 12'd63), 1'b0, '0});
    // Bounds: one past the edge and the far ends of the pixel fields.
    directed.push_back('{make_req(FUNC_TEST, 2'd0, 0, 0, 0, 0, 12'd64, 12'd0), 1'b1, '0});
    directed.push_back('{make_req(FUNC_TEST, 2'd0, 0, 0, 0, 0, 12'h800, 12'h7FF), 1'b1, '0});
    directed.push_back('{make_req(FUNC_TEST, 2'd0, 0, 0, 0, 0, 12'h7FF, 12'hFFF), 1'b1, '0});
    // Extreme clip values, zero w (vertex at the origin) and a negative w.
    directed.push_back('{make_req(FUNC_LOAD, 2'd0, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 12'd0, 12'd0), 1'b1, '0});
    directed.push_back('{make_req(FUNC_LOAD, 2'd1, 32'h8000_0000, 32'h7FFF_FFFF,
                                  32'h8000_0000, 32'h0, 12'd0, 12'd0), 1'b1, '0});
    directed.push_back('{make_req(FUNC_LOAD, 2'd2, 32'h8000_0000, 32'h8000_0000,
                                  32'h8000_0000, 32'h8000_0000, 12'd0, 12'd0), 1'b0, '0});
    directed.push_back('{make_req(FUNC_TEST, 2'd0, 0, 0, 0, 0, 12'd32, 12'd32), 1'b0, '0});
    directed.push_back('{make_req(FUNC_TEST, 2'd0, 0, 0, 0, 0, 12'd1, 12'd62), 1'b0, '0});

    // Reset first; the core then sweeps its store before taking requests,
    // which the handshake absorbs.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    write_reg(CFG_WIDTH, 7'd64);
    write_reg(CFG_HEIGHT, 7'd64);
    write_reg(CFG_CULL, CULL_NONE);

    foreach (directed[i]) send_request(directed[i].req, directed[i].fixed, directed[i].res);
    drain();

    // Random phases. Each starts from an idle core with a new setting; the
    // first few take the extremes, phase index 2 runs with no idling at all.
    sent      = 0;
    per_phase = RAND_ITEMS / PHASES;
    for (int ph_i = 0; ph_i < PHASES; ph_i++) begin
      case (ph_i)
        0: begin pw = 7'd64;  ph = 7'd64;  pc = CULL_NONE;  end
        1: begin pw = 7'd1;   ph = 7'd1;   pc = CULL_FRONT; end
        2: begin pw = 7'd127; ph = 7'd127; pc = CULL_BACK;  end
        3: begin pw = 7'd0;   ph = 7'd64;  pc = CULL_SPARE; end
        4: begin pw = 7'd64;  ph = 7'd1;   pc = CULL_NONE;  end
        default: begin
          pw = $urandom_range(1, 64);
          ph = $urandom_range(1, 64);
          pc = $urandom;
        end
      endcase
      write_reg(CFG_WIDTH, pw);
      write_reg(CFG_HEIGHT, ph);
      write_reg(CFG_CULL, pc);
      calm = (ph_i == 2);

      n_tris = 0;
      while (sent < per_phase * (ph_i + 1)) begin
        // A whole triangle in a random slot order, then pixels against it.
        slots = '{0, 1, 2};
        slots.shuffle();
        if ($urandom_range(0, 1)) begin
          slots[0] = 0;
          slots[1] = 1;
          slots[2] = 2;
        end
        for (int s = 0; s < 3; s++) begin
          send_request(rand_vertex(slots[s]));
          sent++;
        end
        k = $urandom_range(4, 12);
        repeat (k) begin
          case ($urandom_range(0, 19))
            0, 1, 2: r = rand_pixel(FUNC_CLEAR);
            3:       r = rand_pixel(FUNC_SPARE);
            4: begin
              r = rand_vertex($urandom);
              if ($urandom_range(0, 1)) r.slot = SLOT_SPARE;
            end
            default: r = rand_pixel(FUNC_TEST);
          endcase
          send_request(r);
          sent++;
        end
        n_tris++;
      end
      // The sender holds back here until every result of the phase is in.
      drain();
    end
    calm = 1'b0;

    drain();
    repeat (100) @(negedge clk);

    $display("tb: %0d results checked, %0d pixel tests: %0d covered, %0d depth passes",
             n_results, n_tests, n_covered, n_passed);
    $display("tb: %0d triangles culled across %0d settings, %0d mismatches",
             n_culled_tri, PHASES, n_errors);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: %0d results still outstanding", pending_results.size());
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
